>>> rtl/core/nearest_palette_colour_search_core_assert.svh
`ifndef NEAREST_PALETTE_COLOUR_SEARCH_CORE_ASSERT_SVH
`define NEAREST_PALETTE_COLOUR_SEARCH_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define NPCS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nearest palette search: same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define NPCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nearest palette search: next-cycle check failed");

`endif

>>> rtl/core/npcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package npcs_pkg;

    localparam int CH_W      = 8;
    localparam int COL_W     = 3 * CH_W;
    localparam int IDX_W     = 8;
    localparam int SQ_W      = 2 * CH_W;
    localparam int DIST_W    = 18;
    localparam int NUM_CELLS = 3;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    // Data handed from one cell to the next
    typedef struct packed {
        logic              vld;
        logic              last;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] sum;
        logic [COL_W-1:0]  ent;
        logic [COL_W-1:0]  qry;
    } t_cell_bus;

endpackage

`default_nettype wire

>>> rtl/core/nearest_palette_colour_search_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel     Direction  Handshake            Payload
// request     in         start high, busy low i_opcode, i_entry_index, i_red, i_green, i_blue
// result      out        o_best_valid strobe  o_best_index
//
// A write leaves busy low, so writes may come every cycle.
// A query raises busy; the palette RAM is read one entry per cycle, the
// strobe follows the last entry through the cell row and the minimum stage,
// and busy falls the cycle after it; the next request is taken only then.
// Reset is synchronous, active low, and clears control only; palette
// contents are undefined until written. The result cannot be stalled.
module nearest_palette_colour_search_core
    import npcs_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output      logic             busy,
    input  wire logic             i_opcode,
    input  wire logic [IDX_W-1:0] i_entry_index,
    input  wire logic [CH_W-1:0]  i_red,
    input  wire logic [CH_W-1:0]  i_green,
    input  wire logic [CH_W-1:0]  i_blue,
    output      logic             o_best_valid,
    output      logic [IDX_W-1:0] o_best_index
);

    localparam int ADDR_W = $clog2(PALETTE_ENTRIES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_ENTRIES - 1);

    logic              w_accept;
    logic              w_we;
    logic [COL_W-1:0]  w_rdata;
    logic              w_res_vld;
    logic [IDX_W-1:0]  w_res_idx;
    t_cell_bus         w_chain [NUM_CELLS+1];

    logic              r_busy;
    logic              r_issue;
    logic [ADDR_W-1:0] r_addr;
    logic [COL_W-1:0]  r_qry;
    logic              r_rd_vld;
    logic              r_rd_last;
    logic [IDX_W-1:0]  r_rd_idx;

    assign w_accept = start && !r_busy;
    assign w_we     = w_accept && (i_opcode == OP_WRITE)
                      && ({1'b0, i_entry_index} < (IDX_W + 1)'(PALETTE_ENTRIES));

    npcs_ram #(
        .WIDTH (COL_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_entry_index[ADDR_W-1:0]),
        .i_wdata ({i_red, i_green, i_blue}),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_issue;
            if (w_accept && (i_opcode == OP_QUERY)) begin
                r_busy  <= 1'b1;
                r_issue <= 1'b1;
            end else begin
                if (r_issue && (r_addr == LAST_ADDR)) begin
                    r_issue <= 1'b0;
                end
                if (w_res_vld) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_opcode == OP_QUERY)) begin
            r_addr <= '0;
            r_qry  <= {i_red, i_green, i_blue};
        end else if (r_issue) begin
            r_addr <= r_addr + 1'b1;
        end
        // tag travels alongside the registered RAM read
        r_rd_idx  <= IDX_W'(r_addr);
        r_rd_last <= r_addr == LAST_ADDR;
    end

    always_comb begin
        w_chain[0].vld  = r_rd_vld;
        w_chain[0].last = r_rd_last;
        w_chain[0].idx  = r_rd_idx;
        w_chain[0].sum  = '0;
        w_chain[0].ent  = w_rdata;
        w_chain[0].qry  = r_qry;
    end

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        npcs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (w_chain[g]),
            .o_bus   (w_chain[g+1])
        );
    end

    npcs_min u_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bus   (w_chain[NUM_CELLS]),
        .o_valid (w_res_vld),
        .o_index (w_res_idx)
    );

    assign busy         = r_busy;
    assign o_best_valid = w_res_vld;
    assign o_best_index = w_res_idx;

endmodule

`default_nettype wire

>>> rtl/core/npcs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module npcs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/npcs_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One channel of the distance: squares the top byte difference, adds it to
// the running sum and shifts the next channel up for the following cell.
module npcs_cell
    import npcs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_bus i_bus,
    output t_cell_bus      o_bus
);

    logic [CH_W-1:0] w_ent;
    logic [CH_W-1:0] w_qry;
    logic [CH_W-1:0] w_diff;
    logic [SQ_W-1:0] w_sq;
    t_cell_bus       n_pay;
    t_cell_bus       r_pay;
    logic            r_vld;

    assign w_ent  = i_bus.ent[COL_W-1 -: CH_W];
    assign w_qry  = i_bus.qry[COL_W-1 -: CH_W];
    assign w_diff = (w_ent >= w_qry) ? (w_ent - w_qry) : (w_qry - w_ent);
    assign w_sq   = w_diff * w_diff;

    always_comb begin
        n_pay      = i_bus;
        n_pay.sum  = i_bus.sum + DIST_W'(w_sq);
        n_pay.ent  = {i_bus.ent[COL_W-CH_W-1:0], CH_W'(0)};
        n_pay.qry  = {i_bus.qry[COL_W-CH_W-1:0], CH_W'(0)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_bus.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pay <= n_pay;
    end

    always_comb begin
        o_bus     = r_pay;
        o_bus.vld = r_vld;
    end

endmodule

`default_nettype wire

>>> rtl/core/npcs_min.sv
`timescale 1ns / 1ps
`default_nettype none

// Running minimum over the distances leaving the cell row.
module npcs_min
    import npcs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cell_bus        i_bus,
    output      logic             o_valid,
    output      logic [IDX_W-1:0] o_index
);

    logic [DIST_W-1:0] r_best_dist;
    logic [IDX_W-1:0]  r_best_idx;
    logic [IDX_W-1:0]  r_res_idx;
    logic              r_res_vld;
    logic              n_take;

    // entry zero always seeds; strict compare keeps the lowest index on ties
    assign n_take = (i_bus.idx == '0) || (i_bus.sum < r_best_dist);

    always_ff @(posedge i_clk) begin
        if (i_bus.vld && n_take) begin
            r_best_dist <= i_bus.sum;
            r_best_idx  <= i_bus.idx;
        end
        if (i_bus.vld && i_bus.last) begin
            r_res_idx <= n_take ? i_bus.idx : r_best_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= i_bus.vld && i_bus.last;
        end
    end

    assign o_valid = r_res_vld;
    assign o_index = r_res_idx;

endmodule

`default_nettype wire

>>> rtl/core/npcs_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "nearest_palette_colour_search_core_assert.svh"

module npcs_checker
    import npcs_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             i_opcode,
    input wire logic             o_best_valid,
    input wire logic [IDX_W-1:0] o_best_index
);

    `NPCS_ASSERT_NEXT(a_query_sets_busy, start && !busy && (i_opcode == OP_QUERY), busy)
    `NPCS_ASSERT_NEXT(a_write_no_busy, start && !busy && (i_opcode == OP_WRITE), !busy && !o_best_valid)
    `NPCS_ASSERT_NOW(a_result_in_query, o_best_valid, busy)
    `NPCS_ASSERT_NEXT(a_result_ends_query, o_best_valid, !busy && !o_best_valid)
    `NPCS_ASSERT_NOW(a_index_in_range, o_best_valid, {1'b0, o_best_index} < (IDX_W + 1)'(PALETTE_ENTRIES))

endmodule

bind nearest_palette_colour_search_core npcs_checker #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
) u_npcs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_opcode     (i_opcode),
    .o_best_valid (o_best_valid),
    .o_best_index (o_best_index)
);

`default_nettype wire
